// ===== hw/rtl/crf_pkg.sv =====
// Shared types, constants and the CRC byte step for the frame receiver.
// No dependencies; compiled first.
package crf_pkg;

    // Frame layout
    localparam logic [15:0] HEADER_BYTES = 16'd4;
    localparam logic [15:0] CRC_BYTES    = 16'd2;
    localparam logic [15:0] MAX_PAYLOAD  = 16'd256;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Byte roles
    localparam logic [2:0] ROLE_TYPE     = 3'd0;
    localparam logic [2:0] ROLE_CMD      = 3'd1;
    localparam logic [2:0] ROLE_LEN_LO   = 3'd2;
    localparam logic [2:0] ROLE_LEN_HI   = 3'd3;
    localparam logic [2:0] ROLE_PAYLOAD  = 3'd4;
    localparam logic [2:0] ROLE_CRC_LO   = 3'd5;
    localparam logic [2:0] ROLE_CRC_HI   = 3'd6;
    localparam logic [2:0] ROLE_IGNORED  = 3'd7;

    // Verdict codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd1;
    localparam logic [1:0] ERR_SHORT     = 2'd2;
    localparam logic [1:0] ERR_CRC       = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  out_role;
        logic [7:0]  out_byte;
        logic [7:0]  out_index;
        logic        out_done;
        logic        out_ok;
        logic [1:0]  out_error;
        logic [7:0]  out_type;
        logic [7:0]  out_cmd;
        logic [15:0] out_len;
    } t_out_req;

    // One byte through the CRC, MSB first, unrolled.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/crf_if.sv =====
// Valid/ready stream interfaces for the frame receiver's input and output.
// Depends on crf_pkg.
interface crf_in_if;
    import crf_pkg::*;
    logic    valid;
    logic    ready;
    t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface crf_out_if;
    import crf_pkg::*;
    logic     valid;
    logic     ready;
    t_out_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/crc_frame_receiver.sv =====
// Frame receiver: tags each byte of a length-prefixed frame, checks its CRC.
// Depends on crf_pkg and crf_if (crf_in_if, crf_out_if).
//
// Takes one buffer byte per request and gives exactly one result request per
// byte, at up to one byte per clock. The frame is type, cmd, 16-bit length
// (little endian), payload, 16-bit CRC-16/CCITT-FALSE (little endian) over
// header and payload. Each result carries the byte, its role and its payload
// index; the result of the byte flagged in_last also carries the verdict
// (ok, payload too large, short frame, CRC mismatch) with type, cmd and
// length, and the parser returns to its reset state for the next buffer.
// Results are registered. The per-byte parse and the unrolled CRC byte
// step sit between the accept edge and the result register; a two-entry
// output (result register plus skid register) keeps i_in.ready independent
// of o_out.ready, so a stalled consumer costs no throughput until both
// entries are full. Payload is cut-through: on a bad verdict the consumer
// drops the payload it already took.
module crc_frame_receiver (
    input  logic             i_clk,
    input  logic             i_rst_n,
    crf_in_if.sink           i_in,
    crf_out_if.source        o_out
);
    import crf_pkg::*;

    // Parser state
    logic [15:0] r_pos,      n_pos;       // byte position, saturating
    logic [15:0] r_len,      n_len;       // payload length field
    logic [7:0]  r_type,     n_type;
    logic [7:0]  r_cmd,      n_cmd;
    logic [15:0] r_crc,      n_crc;       // running CRC
    logic [7:0]  r_crc_lo,   n_crc_lo;    // received CRC low byte
    logic        r_complete, n_complete;  // CRC high byte seen
    logic        r_matched,  n_matched;

    // Output stage: result register plus skid register
    logic        r_out_valid,  n_out_valid;
    t_out_req    r_out,        n_out;
    logic        r_skid_valid, n_skid_valid;
    t_out_req    r_skid,       n_skid;

    logic        w_acc;
    logic        w_take;
    logic [7:0]  w_b;
    logic [16:0] w_pay_end;   // first position past the payload
    logic [2:0]  w_role;
    logic [7:0]  w_idx;
    logic [1:0]  w_err;
    t_out_req    w_res;

    assign w_acc  = i_in.valid && i_in.ready;
    assign w_take = r_out_valid && o_out.ready;
    assign w_b    = i_in.data.in_byte;

    assign i_in.ready  = !r_skid_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_pay_end = {1'b0, HEADER_BYTES} + {1'b0, r_len};
    assign w_idx     = r_pos[7:0] - HEADER_BYTES[7:0];

    // Byte parse and state update
    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_type     = r_type;
        n_cmd      = r_cmd;
        n_crc      = r_crc;
        n_crc_lo   = r_crc_lo;
        n_complete = r_complete;
        n_matched  = r_matched;
        w_role     = ROLE_IGNORED;
        w_err      = ERR_NONE;
        w_res      = '0;

        if (r_pos == 16'd0) begin
            w_role = ROLE_TYPE;
            n_type = w_b;
        end else if (r_pos == 16'd1) begin
            w_role = ROLE_CMD;
            n_cmd  = w_b;
        end else if (r_pos == 16'd2) begin
            w_role = ROLE_LEN_LO;
            n_len  = {r_len[15:8], w_b};
        end else if (r_pos == 16'd3) begin
            w_role = ROLE_LEN_HI;
            n_len  = {w_b, r_len[7:0]};
        end else if ({1'b0, r_pos} < w_pay_end) begin
            w_role = ROLE_PAYLOAD;
        end else if ({1'b0, r_pos} == w_pay_end && !r_complete) begin
            w_role   = ROLE_CRC_LO;
            n_crc_lo = w_b;
        end else if ({2'b00, r_pos} == ({1'b0, w_pay_end} + 18'd1) && !r_complete) begin
            w_role     = ROLE_CRC_HI;
            n_complete = 1'b1;
            n_matched  = (r_crc == {w_b, r_crc_lo});
        end

        // CRC covers header and payload only
        if (w_role == ROLE_TYPE || w_role == ROLE_CMD || w_role == ROLE_LEN_LO ||
            w_role == ROLE_LEN_HI || w_role == ROLE_PAYLOAD) begin
            n_crc = crc16_byte(r_crc, w_b);
        end

        if (r_pos != 16'hFFFF) begin
            n_pos = r_pos + 16'd1;
        end

        w_res.out_role  = w_role;
        w_res.out_byte  = w_b;
        w_res.out_index = (w_role == ROLE_PAYLOAD) ? w_idx : 8'd0;

        if (i_in.data.in_last) begin
            // verdict order: tiny buffer, oversize, missing CRC, mismatch
            if (r_pos < HEADER_BYTES + CRC_BYTES - 16'd1) begin
                w_err = ERR_SHORT;
            end else if (n_len > MAX_PAYLOAD) begin
                w_err = ERR_TOO_LARGE;
            end else if (!n_complete) begin
                w_err = ERR_SHORT;
            end else if (!n_matched) begin
                w_err = ERR_CRC;
            end
            w_res.out_done  = 1'b1;
            w_res.out_ok    = (w_err == ERR_NONE);
            w_res.out_error = w_err;
            w_res.out_type  = n_type;
            w_res.out_cmd   = n_cmd;
            w_res.out_len   = n_len;

            // back to reset state for the next buffer
            n_pos      = 16'd0;
            n_len      = 16'd0;
            n_type     = 8'd0;
            n_cmd      = 8'd0;
            n_crc      = CRC_INIT;
            n_crc_lo   = 8'd0;
            n_complete = 1'b0;
            n_matched  = 1'b0;
        end
    end

    // Output stage steering
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = w_acc;
                n_skid       = w_res;
            end else begin
                n_out_valid = w_acc;
                n_out       = w_res;
            end
        end else if (w_acc) begin
            n_skid_valid = 1'b1;
            n_skid       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= 16'd0;
            r_len        <= 16'd0;
            r_type       <= 8'd0;
            r_cmd        <= 8'd0;
            r_crc        <= CRC_INIT;
            r_crc_lo     <= 8'd0;
            r_complete   <= 1'b0;
            r_matched    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_pos      <= n_pos;
                r_len      <= n_len;
                r_type     <= n_type;
                r_cmd      <= n_cmd;
                r_crc      <= n_crc;
                r_crc_lo   <= n_crc_lo;
                r_complete <= n_complete;
                r_matched  <= n_matched;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // Skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty result register");

    // Last byte of a buffer re-arms the parser
    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.data.in_last) |=> (r_pos == 16'd0 && r_crc == CRC_INIT))
        else $error("parser not re-armed after last byte");

    // Start of buffer always sees a fresh CRC
    a_fresh_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == 16'd0) |-> (r_crc == CRC_INIT && !r_complete))
        else $error("stale CRC state at start of buffer");

    // CRC high byte can only have been seen past the shortest frame
    a_complete_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_complete |-> (r_pos >= HEADER_BYTES + CRC_BYTES))
        else $error("frame complete before minimum frame length");

endmodule
